// ===== rtl/sc2t_pkg.sv =====
// Shared constants, the scancode table and the result record for the scancode console core.
// No dependencies; both rtl modules refer to it by scoped names.
package sc2t_pkg;

    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    localparam logic [7:0] CHR_NONE  = 8'h00;
    localparam logic [7:0] CHR_BS    = 8'h08;
    localparam logic [7:0] CHR_NL    = 8'h0A;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_ENNEY = 8'hF1;

    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    localparam logic REG_KEY_HANDLER = 1'b0;
    localparam logic REG_KBD_ACTIVE  = 1'b1;

    localparam int CFG_AW = 3;

    typedef struct packed {
        logic        write_valid;
        logic [7:0]  write_char;
        logic [4:0]  write_row;
        logic [6:0]  write_col;
        logic        scroll_up;
        logic [4:0]  cursor_row_out;
        logic [6:0]  cursor_col_out;
        logic [10:0] cursor_offset;
    } res_t;

    function automatic logic [7:0] keymap(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'h02:   ch = "1";
            7'h03:   ch = "2";
            7'h04:   ch = "3";
            7'h05:   ch = "4";
            7'h06:   ch = "5";
            7'h07:   ch = "6";
            7'h08:   ch = "7";
            7'h09:   ch = "8";
            7'h0A:   ch = "9";
            7'h0B:   ch = "0";
            7'h0E:   ch = CHR_BS;
            7'h10:   ch = "q";
            7'h11:   ch = "w";
            7'h12:   ch = "e";
            7'h13:   ch = "r";
            7'h14:   ch = "t";
            7'h15:   ch = "y";
            7'h16:   ch = "u";
            7'h17:   ch = "i";
            7'h18:   ch = "o";
            7'h19:   ch = "p";
            7'h1C:   ch = CHR_NL;
            7'h1E:   ch = "a";
            7'h1F:   ch = "s";
            7'h20:   ch = "d";
            7'h21:   ch = "f";
            7'h22:   ch = "g";
            7'h23:   ch = "h";
            7'h24:   ch = "j";
            7'h25:   ch = "k";
            7'h26:   ch = "l";
            7'h27:   ch = CHR_ENNEY;
            7'h2C:   ch = "z";
            7'h2D:   ch = "x";
            7'h2E:   ch = "c";
            7'h2F:   ch = "v";
            7'h30:   ch = "b";
            7'h31:   ch = "n";
            7'h32:   ch = "m";
            7'h33:   ch = ",";
            7'h34:   ch = ".";
            7'h35:   ch = "-";
            7'h39:   ch = CHR_SPACE;
            default: ch = CHR_NONE;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/sc2t_step.sv =====
// Cursor update for one request: scancode decode, cursor move, clamp and linear offset.
// Depends on sc2t_pkg (keymap, character codes, res_t).
module sc2t_step #(
    parameter int ROWS = sc2t_pkg::ROWS_DEF,
    parameter int COLS = sc2t_pkg::COLS_DEF
) (
    input  logic                    req_type,
    input  logic [7:0]              scan_byte,
    input  logic [4:0]              new_row,
    input  logic [6:0]              new_col,
    input  logic                    key_en,
    input  logic                    kbd_act,
    input  logic [$clog2(ROWS)-1:0] row,
    input  logic [$clog2(COLS)-1:0] col,
    output logic                    has_res,
    output logic [$clog2(ROWS)-1:0] row_next,
    output logic [$clog2(COLS)-1:0] col_next,
    output sc2t_pkg::res_t          res
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);
    localparam int OFF_W = $clog2(ROWS * COLS);
    localparam int RW    = (ROW_W > 5) ? ROW_W : 5;
    localparam int CW    = (COL_W > 7) ? COL_W : 7;
    localparam int OW    = (OFF_W > 11) ? OFF_W : 11;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

    logic [7:0]       ch;
    logic             hit;
    logic [ROW_W-1:0] clamp_r;
    logic [COL_W-1:0] clamp_c;
    logic [ROW_W-1:0] r_f;
    logic [COL_W-1:0] c_f;
    logic [ROW_W-1:0] off_r;
    logic [COL_W-1:0] off_c;
    logic [ROW_W-1:0] wr;
    logic [COL_W-1:0] wc;
    logic             wv;
    logic [7:0]       wch;
    logic             sc;
    logic [OW-1:0]    off;
    logic [RW-1:0]    wr_w;
    logic [CW-1:0]    wc_w;
    logic [RW-1:0]    cr_w;
    logic [CW-1:0]    cc_w;

    assign ch      = sc2t_pkg::keymap(scan_byte[6:0]);
    assign hit     = !scan_byte[7] && key_en && (ch != sc2t_pkg::CHR_NONE);
    assign clamp_r = (32'(new_row) >= ROWS) ? ROW_LAST : ROW_W'(new_row);
    assign clamp_c = (32'(new_col) >= COLS) ? COL_LAST : COL_W'(new_col);

    always_comb
    begin
        r_f = row;
        c_f = col;
        wv  = 1'b0;
        wch = sc2t_pkg::CHR_NONE;
        wr  = '0;
        wc  = '0;
        sc  = 1'b0;
        if (req_type == sc2t_pkg::REQ_SET)
        begin
            if (kbd_act)
            begin
                r_f = clamp_r;
                c_f = clamp_c;
            end
        end
        else if (hit)
        begin
            case (ch)
                sc2t_pkg::CHR_NL:
                begin
                    c_f = '0;
                    if (row == ROW_LAST)
                        sc = 1'b1;
                    else
                        r_f = row + 1'b1;
                end
                sc2t_pkg::CHR_BS:
                begin
                    if (col != '0)
                        c_f = col - 1'b1;
                    else if (row != '0)
                    begin
                        r_f = row - 1'b1;
                        c_f = COL_LAST;
                    end
                    wv  = 1'b1;
                    wch = sc2t_pkg::CHR_SPACE;
                    wr  = r_f;
                    wc  = c_f;
                end
                default:
                begin
                    wv  = 1'b1;
                    wch = ch;
                    wr  = row;
                    wc  = col;
                    if (col == COL_LAST)
                    begin
                        c_f = '0;
                        if (row == ROW_LAST)
                            sc = 1'b1;
                        else
                            r_f = row + 1'b1;
                    end
                    else
                        c_f = col + 1'b1;
                end
            endcase
        end
    end

    assign off_r = (req_type == sc2t_pkg::REQ_SET) ? clamp_r : r_f;
    assign off_c = (req_type == sc2t_pkg::REQ_SET) ? clamp_c : c_f;
    assign off   = OW'(off_r) * OW'(COLS) + OW'(off_c);

    assign has_res  = (req_type == sc2t_pkg::REQ_SET) || hit;
    assign row_next = r_f;
    assign col_next = c_f;

    assign wr_w = RW'(wr);
    assign wc_w = CW'(wc);
    assign cr_w = RW'(r_f);
    assign cc_w = CW'(c_f);

    always_comb
    begin
        res.write_valid    = wv;
        res.write_char     = wch;
        res.write_row      = wr_w[4:0];
        res.write_col      = wc_w[6:0];
        res.scroll_up      = sc;
        res.cursor_row_out = cr_w[4:0];
        res.cursor_col_out = cc_w[6:0];
        res.cursor_offset  = off[10:0];
    end

endmodule

// ===== rtl/scancode_to_text_cursor_core.sv =====
// Top level of the scancode console core: input beat register, cursor state, result register
// and the register port. Depends on sc2t_pkg and sc2t_step.
//
//  channel  | direction | handshake        | contents
//  s_*      | in        | s_tvalid/tready  | request: scancode or set-cursor
//  m_*      | out       | m_tvalid/tready  | screen write, scroll and cursor report
//  apb      | in/out    | psel/penable     | key_handler_present @0, keyboard_active @4
//
// One request per cycle unless a stalled result blocks it; each goes from input beat
// to result beat via the input register, one pass of cursor logic and the result register.
// Reset (rst_n low) clears both stages, puts the cursor at row 0 column 0, and sets
// key_handler_present to 1 and keyboard_active to 0.
// A stalled result holds in the output register; a request that gives no result drops
// out of the input register without waiting on m_tready.
module scancode_to_text_cursor_core #(
    parameter int ROWS = sc2t_pkg::ROWS_DEF,
    parameter int COLS = sc2t_pkg::COLS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // scan_byte, new_row, new_col, zero pad
    input  logic                        s_tuser,   // req_type
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [47:0]                 m_tdata,   // write_char, write_row, write_col,
                                                   // scroll_up, cursor_row_out,
                                                   // cursor_col_out, cursor_offset, zero pad
    output logic                        m_tuser,   // write_valid
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sc2t_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);

    logic             in_v_reg;
    logic             req_reg;
    logic [7:0]       scan_reg;
    logic [4:0]       nrow_reg;
    logic [6:0]       ncol_reg;
    logic             key_en_reg;
    logic             kbd_act_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             out_v_reg;
    sc2t_pkg::res_t   out_reg;

    logic             has_res;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_next;
    sc2t_pkg::res_t   res_next;
    logic             out_free;
    logic             adv;
    logic             cfg_wr;

    sc2t_step #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_step (
        .req_type  (req_reg),
        .scan_byte (scan_reg),
        .new_row   (nrow_reg),
        .new_col   (ncol_reg),
        .key_en    (key_en_reg),
        .kbd_act   (kbd_act_reg),
        .row       (row_reg),
        .col       (col_reg),
        .has_res   (has_res),
        .row_next  (row_next),
        .col_next  (col_next),
        .res       (res_next)
    );

    assign out_free = !out_v_reg || m_tready;
    assign adv      = in_v_reg && (!has_res || out_free);
    assign s_tready = !in_v_reg || adv;
    assign cfg_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            if (s_tready)
                in_v_reg <= s_tvalid;
            if (adv)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (adv && has_res)
                out_v_reg <= 1'b1;
            else if (m_tready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            req_reg  <= s_tuser;
            scan_reg <= s_tdata[7:0];
            nrow_reg <= s_tdata[12:8];
            ncol_reg <= s_tdata[19:13];
        end
        if (adv && has_res)
            out_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_en_reg  <= 1'b1;
            kbd_act_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                sc2t_pkg::REG_KEY_HANDLER: key_en_reg  <= pwdata[0];
                sc2t_pkg::REG_KBD_ACTIVE:  kbd_act_reg <= pwdata[0];
                default:                   key_en_reg  <= key_en_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            sc2t_pkg::REG_KEY_HANDLER: prdata = {31'd0, key_en_reg};
            sc2t_pkg::REG_KBD_ACTIVE:  prdata = {31'd0, kbd_act_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_reg.write_valid;
    assign m_tdata  = {4'd0, out_reg.cursor_offset, out_reg.cursor_col_out,
                       out_reg.cursor_row_out, out_reg.scroll_up, out_reg.write_col,
                       out_reg.write_row, out_reg.write_char};

endmodule

// ===== bench/tb_scancode_to_text_cursor_core.sv =====
// Self-checking bench for scancode_to_text_cursor_core: a directed script, then random scancode
// and set-cursor traffic under several idling mixes, checked beat by beat against a cursor model.
// Depends on rtl/sc2t_pkg.sv and rtl/scancode_to_text_cursor_core.sv.
module tb_scancode_to_text_cursor_core;

    localparam int ROWS           = sc2t_pkg::ROWS_DEF;
    localparam int COLS           = sc2t_pkg::COLS_DEF;
    localparam int IDLE_LIMIT     = 3000;
    localparam int RX_HOLD_CYCLES = 64;
    localparam int DRAIN_CYCLES   = 4;

    typedef struct {
        logic       req;
        logic [7:0] scan;
        logic [4:0] nrow;
        logic [6:0] ncol;
    } keyreq_t;

    typedef struct {
        bit             is_cfg;
        logic           reg_idx;
        logic           reg_val;
        keyreq_t        k;
        bit             typed;
        sc2t_pkg::res_t want;
    } script_row_t;

    typedef struct {
        int tx_pct;
        int rx_pct;
        bit khp;
        bit kact;
        int goal;
        bit pressure;
    } phase_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [sc2t_pkg::CFG_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [7:0]     char_of_code [0:127];
    logic [7:0]     print_codes [$];
    script_row_t    script [$];
    sc2t_pkg::res_t pending [$];

    int   cur_row = 0;
    int   cur_col = 0;
    logic key_on  = 1'b1;
    logic kbd_on  = 1'b0;

    int   mismatches   = 0;
    int   beats_in     = 0;
    int   beats_out    = 0;
    int   cells_seen   = 0;
    int   scrolls_seen = 0;
    int   rx_stall_pct = 0;
    bit   rx_hold_req  = 1'b0;
    int   quiet_cycles = 0;

    scancode_to_text_cursor_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch: %s got %0d expected %0d (beat %0d)", what, got, want, beats_out);
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    task automatic load_keys(input int base, input string keys);
        for (int i = 0; i < keys.len(); i++)
            char_of_code[base + i] = keys[i];
    endtask

    function automatic logic line_feed();
        cur_col = 0;
        if (cur_row + 1 >= ROWS)
        begin
            cur_row = ROWS - 1;
            return 1'b1;
        end
        cur_row = cur_row + 1;
        return 1'b0;
    endfunction

    function automatic bit cursor_step(input keyreq_t k, output sc2t_pkg::res_t r);
        int         rr;
        int         cc;
        logic [7:0] ch;
        r = '0;
        if (k.req == sc2t_pkg::REQ_SET)
        begin
            rr = (int'(k.nrow) >= ROWS) ? ROWS - 1 : int'(k.nrow);
            cc = (int'(k.ncol) >= COLS) ? COLS - 1 : int'(k.ncol);
            if (kbd_on)
            begin
                cur_row = rr;
                cur_col = cc;
            end
            r.cursor_row_out = 5'(cur_row);
            r.cursor_col_out = 7'(cur_col);
            r.cursor_offset  = 11'(rr * COLS + cc);
            return 1'b1;
        end
        if (k.scan[7] || !key_on)
            return 1'b0;
        ch = char_of_code[k.scan[6:0]];
        if (ch == sc2t_pkg::CHR_NONE)
            return 1'b0;
        if (ch == sc2t_pkg::CHR_NL)
            r.scroll_up = line_feed();
        else if (ch == sc2t_pkg::CHR_BS)
        begin
            if (cur_col > 0)
                cur_col = cur_col - 1;
            else if (cur_row > 0)
            begin
                cur_row = cur_row - 1;
                cur_col = COLS - 1;
            end
            r.write_valid = 1'b1;
            r.write_char  = sc2t_pkg::CHR_SPACE;
            r.write_row   = 5'(cur_row);
            r.write_col   = 7'(cur_col);
        end
        else
        begin
            r.write_valid = 1'b1;
            r.write_char  = ch;
            r.write_row   = 5'(cur_row);
            r.write_col   = 7'(cur_col);
            cur_col = cur_col + 1;
            if (cur_col >= COLS)
                r.scroll_up = line_feed();
        end
        r.cursor_row_out = 5'(cur_row);
        r.cursor_col_out = 7'(cur_col);
        r.cursor_offset  = 11'(cur_row * COLS + cur_col);
        return 1'b1;
    endfunction

    function automatic void add_key(input logic req, input logic [7:0] scan,
                                    input logic [4:0] nrow, input logic [6:0] ncol);
        script_row_t row;
        row = '{default: '0};
        row.k = '{req, scan, nrow, ncol};
        script.push_back(row);
    endfunction

    function automatic void add_known(input logic req, input logic [7:0] scan,
                                      input logic [4:0] nrow, input logic [6:0] ncol,
                                      input sc2t_pkg::res_t want);
        add_key(req, scan, nrow, ncol);
        script[$].typed = 1'b1;
        script[$].want  = want;
    endfunction

    function automatic void add_reg(input logic idx, input logic val);
        script_row_t row;
        row = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        script.push_back(row);
    endfunction

    task automatic send_key(input keyreq_t k, output bit gave, output sc2t_pkg::res_t r);
        s_tvalid <= 1'b1;
        s_tuser  <= k.req;
        s_tdata  <= {4'b0, k.ncol, k.nrow, k.scan};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_in++;
        gave = cursor_step(k, r);
    endtask

    task automatic tx_gap(input int pct);
        while (int'($urandom_range(0, 99)) < pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'b0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == sc2t_pkg::REG_KEY_HANDLER)
            key_on = val;
        else
            kbd_on = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {31'b0, val})
            report_mismatch("register readback", int'(prdata), int'(val));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: random stall, or a long hold-off on request
    always @(posedge clk)
    begin
        if (rx_hold_req)
        begin
            m_tready <= 1'b0;
            repeat (RX_HOLD_CYCLES)
                @(posedge clk);
            rx_hold_req = 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        sc2t_pkg::res_t got;
        sc2t_pkg::res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.write_valid    = m_tuser;
            got.write_char     = m_tdata[7:0];
            got.write_row      = m_tdata[12:8];
            got.write_col      = m_tdata[19:13];
            got.scroll_up      = m_tdata[20];
            got.cursor_row_out = m_tdata[25:21];
            got.cursor_col_out = m_tdata[32:26];
            got.cursor_offset  = m_tdata[43:33];
            beats_out++;
            cells_seen   += int'(got.write_valid);
            scrolls_seen += int'(got.scroll_up);
            if (pending.size() == 0)
                report_mismatch("result beat with nothing pending", 1, 0);
            else
            begin
                want = pending.pop_front();
                check_field("write_valid", int'(got.write_valid), int'(want.write_valid));
                check_field("write_char", int'(got.write_char), int'(want.write_char));
                check_field("write_row", int'(got.write_row), int'(want.write_row));
                check_field("write_col", int'(got.write_col), int'(want.write_col));
                check_field("scroll_up", int'(got.scroll_up), int'(want.scroll_up));
                check_field("cursor_row_out", int'(got.cursor_row_out),
                            int'(want.cursor_row_out));
                check_field("cursor_col_out", int'(got.cursor_col_out),
                            int'(want.cursor_col_out));
                check_field("cursor_offset", int'(got.cursor_offset),
                            int'(want.cursor_offset));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: %0d cycles without a beat, %0d results pending",
                     quiet_cycles, pending.size());
            $display("[scancode_to_text_cursor_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        phase_t         plan [6];
        keyreq_t        k;
        sc2t_pkg::res_t r;
        bit             gave;
        int             counted;
        int             p;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;

        for (int i = 0; i < 128; i++)
            char_of_code[i] = sc2t_pkg::CHR_NONE;
        load_keys(8'h02, "1234567890");
        load_keys(8'h10, "qwertyuiop");
        load_keys(8'h1E, "asdfghjkl");
        load_keys(8'h2C, "zxcvbnm,.-");
        char_of_code[8'h0E] = sc2t_pkg::CHR_BS;
        char_of_code[8'h1C] = sc2t_pkg::CHR_NL;
        char_of_code[8'h27] = sc2t_pkg::CHR_ENNEY;
        char_of_code[8'h39] = sc2t_pkg::CHR_SPACE;
        for (int i = 0; i < 128; i++)
            if (char_of_code[i] != sc2t_pkg::CHR_NONE && char_of_code[i] != sc2t_pkg::CHR_BS &&
                char_of_code[i] != sc2t_pkg::CHR_NL)
                print_codes.push_back(8'(i));

        add_known(sc2t_pkg::REQ_SET, 8'h00, 5'd31, 7'd127,
                  sc2t_pkg::res_t'{1'b0, sc2t_pkg::CHR_NONE, 5'd0, 7'd0, 1'b0, 5'd0, 7'd0,
                                   11'd1999});
        add_known(sc2t_pkg::REQ_SET, 8'hFF, 5'd0, 7'd0,
                  sc2t_pkg::res_t'{1'b0, sc2t_pkg::CHR_NONE, 5'd0, 7'd0, 1'b0, 5'd0, 7'd0,
                                   11'd0});
        add_known(sc2t_pkg::REQ_SCAN, 8'h0E, 5'd31, 7'd127,
                  sc2t_pkg::res_t'{1'b1, sc2t_pkg::CHR_SPACE, 5'd0, 7'd0, 1'b0, 5'd0, 7'd0,
                                   11'd0});
        add_known(sc2t_pkg::REQ_SCAN, 8'h1E, 5'd0, 7'd0,
                  sc2t_pkg::res_t'{1'b1, "a", 5'd0, 7'd0, 1'b0, 5'd0, 7'd1, 11'd1});
        add_key(sc2t_pkg::REQ_SCAN, 8'h9E, 5'd0, 7'd0);
        add_key(sc2t_pkg::REQ_SCAN, 8'hFF, 5'd0, 7'd0);
        add_key(sc2t_pkg::REQ_SCAN, 8'h00, 5'd0, 7'd0);
        add_key(sc2t_pkg::REQ_SCAN, 8'h7F, 5'd0, 7'd0);
        add_key(sc2t_pkg::REQ_SCAN, 8'h80, 5'd0, 7'd0);
        add_known(sc2t_pkg::REQ_SCAN, 8'h27, 5'd0, 7'd0,
                  sc2t_pkg::res_t'{1'b1, sc2t_pkg::CHR_ENNEY, 5'd0, 7'd1, 1'b0, 5'd0, 7'd2,
                                   11'd2});
        add_key(sc2t_pkg::REQ_SCAN, 8'h39, 5'd0, 7'd0);
        add_key(sc2t_pkg::REQ_SCAN, 8'h1C, 5'd0, 7'd0);
        add_key(sc2t_pkg::REQ_SCAN, 8'h0E, 5'd0, 7'd0);
        add_key(sc2t_pkg::REQ_SCAN, 8'h02, 5'd0, 7'd0);
        add_key(sc2t_pkg::REQ_SCAN, 8'h0B, 5'd0, 7'd0);
        add_key(sc2t_pkg::REQ_SCAN, 8'h35, 5'd0, 7'd0);
        add_key(sc2t_pkg::REQ_SCAN, 8'h10, 5'd0, 7'd0);
        add_reg(sc2t_pkg::REG_KBD_ACTIVE, 1'b1);
        add_key(sc2t_pkg::REQ_SET, 8'h00, 5'd24, 7'd79);
        add_key(sc2t_pkg::REQ_SCAN, 8'h2C, 5'd0, 7'd0);
        add_key(sc2t_pkg::REQ_SET, 8'h00, 5'd31, 7'd126);
        add_key(sc2t_pkg::REQ_SCAN, 8'h1C, 5'd0, 7'd0);
        add_key(sc2t_pkg::REQ_SET, 8'h00, 5'd5, 7'd0);
        add_key(sc2t_pkg::REQ_SCAN, 8'h0E, 5'd0, 7'd0);
        add_reg(sc2t_pkg::REG_KEY_HANDLER, 1'b0);
        add_key(sc2t_pkg::REQ_SCAN, 8'h1E, 5'd0, 7'd0);
        add_key(sc2t_pkg::REQ_SET, 8'h00, 5'd2, 7'd3);

        plan[0] = '{0, 0, 1'b1, 1'b1, 150, 1'b0};
        plan[1] = '{74, 0, 1'b1, 1'b0, 130, 1'b0};
        plan[2] = '{0, 74, 1'b0, 1'b1, 30, 1'b0};
        plan[3] = '{0, 74, 1'b1, 1'b1, 115, 1'b0};
        plan[4] = '{31, 31, 1'b1, 1'b1, 120, 1'b0};
        plan[5] = '{0, 0, 1'b1, 1'b0, 80, 1'b1};

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                drain();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
            begin
                send_key(script[i].k, gave, r);
                if (script[i].typed)
                    pending.push_back(script[i].want);
                else if (gave)
                    pending.push_back(r);
            end
        end

        foreach (plan[ph])
        begin
            drain();
            write_reg(sc2t_pkg::REG_KEY_HANDLER, plan[ph].khp);
            write_reg(sc2t_pkg::REG_KBD_ACTIVE, plan[ph].kact);
            rx_stall_pct = plan[ph].rx_pct;
            counted = 0;
            while (counted < plan[ph].goal)
            begin
                k.req  = sc2t_pkg::REQ_SCAN;
                k.nrow = 5'($urandom_range(0, 31));
                k.ncol = 7'($urandom_range(0, 127));
                p = int'($urandom_range(0, 99));
                if (p < 8)
                begin
                    k.req  = sc2t_pkg::REQ_SET;
                    k.scan = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 1))
                    begin
                        k.nrow = 5'($urandom_range(20, 31));
                        k.ncol = 7'($urandom_range(70, 127));
                    end
                end
                else if (p < 18)
                    k.scan = 8'h1C;
                else if (p < 28)
                    k.scan = 8'h0E;
                else if (p < 88)
                    k.scan = print_codes[$urandom_range(0, print_codes.size() - 1)];
                else if (p < 94)
                    k.scan = print_codes[$urandom_range(0, print_codes.size() - 1)] | 8'h80;
                else
                    k.scan = 8'($urandom_range(0, 255));
                tx_gap(plan[ph].tx_pct);
                send_key(k, gave, r);
                counted++;
                if (gave)
                    pending.push_back(r);
                if (plan[ph].pressure && counted == 10)
                    rx_hold_req = 1'b1;
                if (plan[ph].pressure && counted == 50)
                begin
                    s_tvalid <= 1'b0;
                    while (pending.size() != 0)
                        @(posedge clk);
                    @(posedge clk);
                end
            end
        end

        drain();
        repeat (8)
            @(posedge clk);
        $display("covered %0d request beats and %0d result beats: %0d cell writes, %0d scrolls",
                 beats_in, beats_out, cells_seen, scrolls_seen);
        $display("directed script, six random phases with sender and receiver idling,",
                 " a receiver hold-off and a drain pause");
        if (mismatches == 0)
            $display("[scancode_to_text_cursor_core] OK");
        else
            $display("[scancode_to_text_cursor_core] ERROR");
        $finish;
    end
endmodule
